// File: sv/srpq_pkg.sv
package srpq_pkg;

	// Operation codes carried on the op field.
	localparam logic [1:0] OP_POP         = 2'd0;
	localparam logic [1:0] OP_PUSH_SORTED = 2'd1;
	localparam logic [1:0] OP_PUSH_TAIL   = 2'd2;

	// Status codes returned with every result.
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	// What a cell loads at the next clock edge.
	typedef enum logic [1:0] {
		CELL_HOLD      = 2'd0,
		CELL_LOAD      = 2'd1,
		CELL_FROM_PREV = 2'd2,
		CELL_FROM_NEXT = 2'd3
	} cell_mode_t;

endpackage

// File: sv/srpq_cell.sv
module srpq_cell #(
	parameter int ITEM_BITS = 16,
	parameter int KEY_BITS  = 32
) (
	input  logic                   clk,
	input  srpq_pkg::cell_mode_t   mode,
	input  logic                   occupied,
	input  logic [ITEM_BITS-1:0]   new_item,
	input  logic [KEY_BITS-1:0]    new_key,
	input  logic [ITEM_BITS-1:0]   prev_item,
	input  logic [KEY_BITS-1:0]    prev_key,
	input  logic [ITEM_BITS-1:0]   next_item,
	input  logic [KEY_BITS-1:0]    next_key,
	output logic                   greater,
	output logic [ITEM_BITS-1:0]   cur_item,
	output logic [KEY_BITS-1:0]    cur_key
);

	logic [ITEM_BITS-1:0] item_q;
	logic [KEY_BITS-1:0]  key_q;

	// An occupied cell whose key is above the new key is a candidate insertion point.
	assign greater  = occupied && (key_q > new_key);
	assign cur_item = item_q;
	assign cur_key  = key_q;

	// The entry holds, takes the new entry, or moves one place along the row.
	always_ff @(posedge clk) begin
		case (mode)
			srpq_pkg::CELL_LOAD: begin
				item_q <= new_item;
				key_q  <= new_key;
			end
			srpq_pkg::CELL_FROM_PREV: begin
				item_q <= prev_item;
				key_q  <= prev_key;
			end
			srpq_pkg::CELL_FROM_NEXT: begin
				item_q <= next_item;
				key_q  <= next_key;
			end
			default: begin
				item_q <= item_q;
				key_q  <= key_q;
			end
		endcase
	end

endmodule

// File: sv/sorted_ring_priority_queue_core.sv
// Sorted priority queue built as a row of DEPTH cells, cell 0 holding the head.
// One operation is accepted per clock cycle and its result is registered in the
// output register; the input side keeps accepting while the result waits,
// provided the output register is free or being taken in the same cycle. In that
// cycle every cell compares its key with the new key, a prefix network over the
// row finds the first greater entry, and each cell loads the new entry, its left
// or right neighbor, or holds. A sorted push goes before the first stored key that
// is strictly greater, so equal keys leave in arrival order; a tail push appends;
// a pop shifts the row toward the head. Pushes into a full queue and pops from an
// empty one change nothing and are reported in status. Cell contents are not reset.
module sorted_ring_priority_queue_core #(
	parameter int DEPTH     = 256,
	parameter int ITEM_BITS = 16,
	parameter int KEY_BITS  = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           op,
	input  logic [ITEM_BITS-1:0] item,
	input  logic [KEY_BITS-1:0]  key,
	output logic                 res_valid,
	input  logic                 res_ready,
	output logic [ITEM_BITS-1:0] out_item,
	output logic [KEY_BITS-1:0]  out_key,
	output logic                 out_valid,
	output logic                 is_empty,
	output logic [1:0]           status
);

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int LVLS  = $clog2(DEPTH);

	logic [CNT_W-1:0]     count_q;
	logic [CNT_W-1:0]     count_next;
	logic                 res_valid_q;
	logic [ITEM_BITS-1:0] out_item_q;
	logic [KEY_BITS-1:0]  out_key_q;
	logic                 out_valid_q;
	logic                 is_empty_q;
	logic [1:0]           status_q;

	logic                 accept;
	logic                 q_empty;
	logic                 q_full;
	logic                 is_push;
	logic                 do_pop;
	logic                 do_push;

	logic [DEPTH-1:0]     gt_vec;
	logic [DEPTH-1:0]     occ_vec;
	logic [DEPTH-1:0]     at_cnt_vec;
	logic [DEPTH-1:0]     incl_vec;
	logic [DEPTH-1:0]     before_vec;
	logic [DEPTH-1:0]     ins_vec;
	logic [DEPTH-1:0]     shift_vec;
	logic                 use_gt;

	logic [ITEM_BITS-1:0] cell_item [DEPTH];
	logic [KEY_BITS-1:0]  cell_key  [DEPTH];

	// Handshake and queue conditions.
	assign in_ready = !res_valid_q || res_ready;
	assign accept   = in_valid && in_ready;
	assign q_empty  = (count_q == '0);
	assign q_full   = (count_q == CNT_W'(DEPTH));
	assign is_push  = (op == srpq_pkg::OP_PUSH_SORTED) || (op == srpq_pkg::OP_PUSH_TAIL);
	assign do_pop   = accept && (op == srpq_pkg::OP_POP) && !q_empty;
	assign do_push  = accept && is_push && !q_full;

	always_comb begin
		count_next = count_q;
		if (do_pop) begin
			count_next = count_q - CNT_W'(1);
		end else if (do_push) begin
			count_next = count_q + CNT_W'(1);
		end
	end

	// Prefix OR over the compare results: a cell lies past the insertion point
	// when some cell closer to the head holds a greater key.
	always_comb begin
		incl_vec = gt_vec;
		for (int l = 0; l < LVLS; l++) begin
			incl_vec = incl_vec | (incl_vec << (1 << l));
		end
		before_vec = {incl_vec[DEPTH-2:0], 1'b0};
	end

	// A sorted push with a greater key present inserts there; otherwise the
	// new entry lands just past the last occupied cell.
	assign use_gt    = (op == srpq_pkg::OP_PUSH_SORTED) && incl_vec[DEPTH-1];
	assign ins_vec   = use_gt ? (gt_vec & ~before_vec) : at_cnt_vec;
	assign shift_vec = use_gt ? before_vec : '0;

	// The row of cells.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		srpq_pkg::cell_mode_t mode;
		logic [ITEM_BITS-1:0] prev_item;
		logic [KEY_BITS-1:0]  prev_key;
		logic [ITEM_BITS-1:0] next_item;
		logic [KEY_BITS-1:0]  next_key;

		assign occ_vec[i]    = (CNT_W'(i) < count_q);
		assign at_cnt_vec[i] = (CNT_W'(i) == count_q);

		// The head cell has no left neighbor and the last cell no right one.
		if (i == 0) begin : g_first
			assign prev_item = item;
			assign prev_key  = key;
		end else begin : g_mid_prev
			assign prev_item = cell_item[i-1];
			assign prev_key  = cell_key[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign next_item = item;
			assign next_key  = key;
		end else begin : g_mid_next
			assign next_item = cell_item[i+1];
			assign next_key  = cell_key[i+1];
		end

		always_comb begin
			mode = srpq_pkg::CELL_HOLD;
			if (do_pop) begin
				mode = srpq_pkg::CELL_FROM_NEXT;
			end else if (do_push) begin
				if (ins_vec[i]) begin
					mode = srpq_pkg::CELL_LOAD;
				end else if (shift_vec[i]) begin
					mode = srpq_pkg::CELL_FROM_PREV;
				end
			end
		end

		srpq_cell #(
			.ITEM_BITS(ITEM_BITS),
			.KEY_BITS (KEY_BITS)
		) u_cell (
			.clk      (clk),
			.mode     (mode),
			.occupied (occ_vec[i]),
			.new_item (item),
			.new_key  (key),
			.prev_item(prev_item),
			.prev_key (prev_key),
			.next_item(next_item),
			.next_key (next_key),
			.greater  (gt_vec[i]),
			.cur_item (cell_item[i]),
			.cur_key  (cell_key[i])
		);
	end

	// Fill count and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_next;
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Result register, loaded with each accepted transaction.
	always_ff @(posedge clk) begin
		if (accept) begin
			out_item_q  <= do_pop ? cell_item[0] : '0;
			out_key_q   <= do_pop ? cell_key[0] : '0;
			out_valid_q <= do_pop;
			is_empty_q  <= (count_next == '0);
			if ((op == srpq_pkg::OP_POP) && q_empty) begin
				status_q <= srpq_pkg::ST_EMPTY;
			end else if (is_push && q_full) begin
				status_q <= srpq_pkg::ST_FULL;
			end else begin
				status_q <= srpq_pkg::ST_OK;
			end
		end
	end

	assign res_valid = res_valid_q;
	assign out_item  = out_item_q;
	assign out_key   = out_key_q;
	assign out_valid = out_valid_q;
	assign is_empty  = is_empty_q;
	assign status    = status_q;

	// The fill count never passes the number of cells.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("fill count above depth");

	// A pop on a non-empty queue returns an entry in the next result.
	a_pop_returns: assert property (@(posedge clk) disable iff (!arst_n)
		do_pop |=> (res_valid_q && out_valid_q && (status_q == srpq_pkg::ST_OK)))
		else $error("pop did not return an entry");

	// A push into a full queue is flagged and leaves the count alone.
	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_push && q_full) |=> ((status_q == srpq_pkg::ST_FULL) && q_full))
		else $error("full push not dropped");

	// The reported empty flag agrees with the fill count while a result is shown.
	a_empty_match: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> (is_empty_q == q_empty))
		else $error("empty flag disagrees with fill count");

endmodule
